// ===== design/lkc_pkg.sv =====
package lkc_pkg;

    localparam int KEY_W     = 32;
    localparam int CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CAP_W-1:0]        cap_t;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

endpackage

// ===== design/lru_key_cache.sv =====
// lru_key_cache: fully associative key store with LRU replacement.
// Command channel: an item (mode, key) is taken on a clock edge with start
// high and busy low. busy is always low, so an item can enter every cycle.
// Result channel: done pulses for one cycle with hit, evicted_valid and
// evicted_key; the receiver cannot stall it, so results are never held.
// Each item passes one input register, then key match, victim pick and rank
// update in a single combinational pass feeding the result register and the
// entry state. Throughput is one item per cycle; each item sees the state
// left by the one before it.
// Config channel: cfg_valid/cfg_ready write capacity (cfg_ready always
// high); write it only while no item is in flight. Capacity 0 acts as 1,
// values above ENTRIES act as ENTRIES.
// Reset empties the store (all entries invalid, count zero) and sets the
// capacity to 16; it takes effect at once, with no clearing pass.
module lru_key_cache #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          mode,
    input  lkc_pkg::key_t key,
    output logic          done,
    output logic          hit,
    output logic          evicted_valid,
    output lkc_pkg::key_t evicted_key,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  lkc_pkg::cap_t cfg_data
);
    import lkc_pkg::*;

    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;
    localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);
    localparam logic [CMPW-1:0] ONE_C     = CMPW'(1);

    cap_t                cap_reg;
    logic                in_vld_reg;
    mode_t               in_mode_reg;
    key_t                in_key_reg;
    key_t                keys_reg  [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [RW-1:0]       rank_reg  [ENTRIES];
    logic [RW-1:0]       rank_next [ENTRIES];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                done_reg;
    logic                hit_reg;
    logic                ev_vld_reg;
    key_t                ev_key_reg;

    logic                accept;
    logic [ENTRIES-1:0]  match_sel;
    logic                match_any;
    logic [ENTRIES-1:0]  free_sel;
    logic                free_any;
    logic [ENTRIES-1:0]  victim_sel;
    logic [ENTRIES-1:0]  target_sel;
    logic [RW-1:0]       touch_rank;
    logic [RW-1:0]       last_rank;
    logic [CMPW-1:0]     eff_cap;
    logic [CMPW-1:0]     count_ext;
    logic                full;
    logic                do_touch;
    logic                do_evict;
    logic                do_fill;
    logic                do_install;
    key_t                victim_key;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        eff_cap = CMPW'(cap_reg);
        if (eff_cap == '0)
        begin
            eff_cap = ONE_C;
        end
        if (eff_cap > ENTRIES_C)
        begin
            eff_cap = ENTRIES_C;
        end
        count_ext = CMPW'(count_reg);
        full      = (count_ext >= eff_cap) || (count_ext >= ENTRIES_C);
        last_rank = RW'(count_reg - CW'(1));
    end

    always_comb
    begin
        match_sel  = '0;
        match_any  = 1'b0;
        free_sel   = '0;
        free_any   = 1'b0;
        victim_sel = '0;
        touch_rank = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!match_any && valid_reg[i] && keys_reg[i] == in_key_reg)
            begin
                match_sel[i] = 1'b1;
                match_any    = 1'b1;
            end
            if (!free_any && !valid_reg[i])
            begin
                free_sel[i] = 1'b1;
                free_any    = 1'b1;
            end
            victim_sel[i] = valid_reg[i] && (rank_reg[i] == last_rank);
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_sel[i])
            begin
                touch_rank = touch_rank | rank_reg[i];
            end
            if (victim_sel[i])
            begin
                victim_key = victim_key | keys_reg[i];
            end
        end
    end

    always_comb
    begin
        do_touch   = in_vld_reg && match_any;
        do_evict   = in_vld_reg && !match_any && (in_mode_reg == MODE_INSERT) && full;
        do_fill    = in_vld_reg && !match_any && (in_mode_reg == MODE_INSERT) && !full
                     && free_any;
        do_install = do_evict || do_fill;
        target_sel = do_evict ? victim_sel : free_sel;
        count_next = do_fill ? (count_reg + CW'(1)) : count_reg;
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (do_touch)
            begin
                if (valid_reg[i] && rank_reg[i] < touch_rank)
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
                if (match_sel[i])
                begin
                    rank_next[i] = '0;
                end
            end
            else if (do_install)
            begin
                if (target_sel[i])
                begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            count_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_mode_reg <= mode_t'(mode);
            in_key_reg  <= key;
        end
        if (in_vld_reg)
        begin
            hit_reg    <= match_any;
            ev_vld_reg <= do_evict;
            ev_key_reg <= do_evict ? victim_key : '0;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (do_install && target_sel[i])
            begin
                keys_reg[i] <= in_key_reg;
            end
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_vld_reg;
    assign evicted_key   = ev_key_reg;

endmodule

// ===== tb/tb_lru_key_cache.sv =====
module tb_lru_key_cache;

    import lkc_pkg::*;

    localparam int ENTRIES        = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int CHUNKS         = 11;
    localparam int CHUNK_ITEMS    = 150;
    localparam int POOL_MAX       = 20;

    typedef enum logic
    {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        logic hit;
        logic evicted_valid;
        key_t evicted_key;
    } lookup_t;

    typedef struct packed
    {
        row_kind_t kind;
        mode_t     mode;
        key_t      key;
        cap_t      cap;
        logic      fixed;
        lookup_t   want;
    } dir_row_t;

    localparam lookup_t MISS_NONE = '{1'b0, 1'b0, 32'sh0};
    localparam lookup_t HIT_NONE  = '{1'b1, 1'b0, 32'sh0};

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  start     = 1'b0;
    mode_t mode      = MODE_INSERT;
    key_t  key       = '0;
    logic  cfg_valid = 1'b0;
    cap_t  cfg_data  = '0;
    logic  busy;
    logic  done;
    logic  hit;
    logic  evicted_valid;
    key_t  evicted_key;
    logic  cfg_ready;

    lru_key_cache #(.ENTRIES(ENTRIES)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .key           (key),
        .done          (done),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // shadow copy of the cache
    key_t       shadow_key  [ENTRIES];
    logic       shadow_live [ENTRIES];
    logic [3:0] shadow_age  [ENTRIES];
    logic [4:0] shadow_count;
    cap_t       shadow_cap;

    lookup_t pending_lookups [$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;

    dir_row_t dir_rows [18];
    key_t     key_pool [POOL_MAX];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic lookup_t cache_access(mode_t m, key_t k);
        lookup_t    r;
        int         found;
        int         place;
        logic [3:0] age;
        logic [4:0] limit;
        r     = MISS_NONE;
        found = -1;
        place = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && shadow_live[i] && shadow_key[i] == k)
                found = i;
        if (found >= 0)
        begin
            r.hit = 1'b1;
            age   = shadow_age[found];
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_live[i] && shadow_age[i] < age)
                    shadow_age[i] = shadow_age[i] + 4'd1;
            shadow_age[found] = 4'd0;
        end
        else if (m == MODE_INSERT)
        begin
            limit = (shadow_cap == 0) ? 5'd1 :
                    (shadow_cap > ENTRIES) ? 5'(ENTRIES) : shadow_cap;
            if (shadow_count >= limit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (shadow_live[i] && (place < 0 || shadow_age[i] > shadow_age[place]))
                        place = i;
                r.evicted_valid = 1'b1;
                r.evicted_key   = shadow_key[place];
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (place < 0 && !shadow_live[i])
                        place = i;
                shadow_count = shadow_count + 5'd1;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_live[i] && i != place)
                    shadow_age[i] = shadow_age[i] + 4'd1;
            shadow_key[place]  = k;
            shadow_live[place] = 1'b1;
            shadow_age[place]  = 4'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input key_t got, input key_t want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_item(input mode_t m, input key_t k, input int idle_pct,
                             input logic drain, input logic fixed, input lookup_t fixed_res);
        lookup_t r;
        logic    gap;
        gap = ($urandom_range(0, 99) < idle_pct);
        if (drain || gap)
        begin
            start <= 1'b0;
            if (drain)
                wait_drained();
            if (gap)
            begin
                @(posedge clk);
                while ($urandom_range(0, 99) < idle_pct)
                    @(posedge clk);
            end
        end
        start <= 1'b1;
        mode  <= m;
        key   <= k;
        do
            @(posedge clk);
        while (busy);
        r = cache_access(m, k);
        if (fixed)
            r = fixed_res;
        pending_lookups = {pending_lookups, r};
    endtask

    task automatic write_capacity(input cap_t v);
        start <= 1'b0;
        wait_drained();
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_cap = v;
        cfg_valid <= 1'b0;
    endtask

    // result checking
    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result with no item pending", evicted_key, '0);
            else
            begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", key_t'(hit), key_t'(want.hit));
                if (evicted_valid !== want.evicted_valid)
                    report_mismatch("evicted_valid", key_t'(evicted_valid),
                                    key_t'(want.evicted_valid));
                if (evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", evicted_key, want.evicted_key);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int   pool_n;
        int   idle_pct;
        cap_t caps [CHUNKS];
        key_t k;
        mode_t m;

        caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd8, 5'd2, 5'd15, 5'd17, 5'd3, 5'd16};

        dir_rows = '{
            '{ROW_ITEM, MODE_QUERY,  32'sh00000000, 5'd0,  1'b1, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh80000000, 5'd0,  1'b1, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh7FFFFFFF, 5'd0,  1'b1, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh00000000, 5'd0,  1'b1, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'shFFFFFFFF, 5'd0,  1'b1, MISS_NONE},
            '{ROW_ITEM, MODE_QUERY,  32'sh7FFFFFFF, 5'd0,  1'b1, HIT_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh80000000, 5'd0,  1'b1, HIT_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh80000000, 5'd0,  1'b1, HIT_NONE},
            '{ROW_ITEM, MODE_QUERY,  32'sh00000005, 5'd0,  1'b1, MISS_NONE},
            // capacity 0 acts as 1, and is below the occupied count
            '{ROW_CFG,  MODE_INSERT, 32'sh0,        5'd0,  1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh00000005, 5'd0,  1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh00000006, 5'd0,  1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_QUERY,  32'sh00000006, 5'd0,  1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_QUERY,  32'sh80000000, 5'd0,  1'b0, MISS_NONE},
            // saturates to ENTRIES
            '{ROW_CFG,  MODE_INSERT, 32'sh0,        5'd31, 1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'sh55555555, 5'd0,  1'b0, MISS_NONE},
            '{ROW_ITEM, MODE_INSERT, 32'shAAAAAAAA, 5'd0,  1'b0, MISS_NONE},
            '{ROW_CFG,  MODE_INSERT, 32'sh0,        5'd1,  1'b0, MISS_NONE}
        };

        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i]  = '0;
            shadow_live[i] = 1'b0;
            shadow_age[i]  = '0;
        end
        shadow_count = '0;
        shadow_cap   = CAP_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_capacity(dir_rows[i].cap);
            else
                send_item(dir_rows[i].mode, dir_rows[i].key, 0, 1'b0,
                          dir_rows[i].fixed, dir_rows[i].want);
        end
        send_item(MODE_INSERT, 32'sh7FFFFFFF, 0, 1'b0, 1'b0, MISS_NONE);
        send_item(MODE_QUERY, 32'shAAAAAAAA, 0, 1'b0, 1'b0, MISS_NONE);

        for (int c = 0; c < CHUNKS; c++)
        begin
            write_capacity(caps[c]);
            idle_pct = (c < 4) ? 19 : (c < 8) ? 50 : 0;
            pool_n = ((caps[c] == 0) ? 1 : (caps[c] > ENTRIES) ? ENTRIES : int'(caps[c]))
                     + $urandom_range(1, 4);
            key_pool[0] = 32'sh80000000;
            key_pool[1] = 32'sh7FFFFFFF;
            key_pool[2] = 32'sh00000000;
            key_pool[3] = 32'shFFFFFFFF;
            for (int p = 4; p < POOL_MAX; p++)
                key_pool[p] = $urandom;
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    k = $urandom;
                m = ($urandom_range(0, 99) < 65) ? MODE_INSERT : MODE_QUERY;
                send_item(m, k, idle_pct, ($urandom_range(0, 99) < 2), 1'b0, MISS_NONE);
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
